FILE: rtl/core/tcce_pkg.sv
// shared types and constants for the text console character engine
// no dependencies; imported by text_console_character_engine_unit
package tcce_pkg;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_FILL,
        ST_SCR_PRE,
        ST_SCR,
        ST_BLANK,
        ST_DONE
    } t_state;

    localparam logic [7:0] CH_BS       = 8'd8;
    localparam logic [7:0] CH_TAB      = 8'd9;
    localparam logic [7:0] CH_LF       = 8'd10;
    localparam logic [7:0] CH_FF       = 8'd12;
    localparam logic [7:0] CH_CR       = 8'd13;
    localparam logic [7:0] CH_SPACE    = 8'd32;
    localparam logic [7:0] CH_PRINT_LO = 8'd32;
    localparam logic [7:0] CH_PRINT_HI = 8'd126;

    localparam logic [7:0] ATTR_RESET  = 8'd14;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;
    localparam int INDEX_W    = 11;
    localparam int CELL_W     = 16;
    localparam int OUT_ROW_W  = 5;
    localparam int OUT_COL_W  = 7;

endpackage

FILE: rtl/core/text_console_character_engine_unit.sv
// text console character engine: cursor logic, sequencer and screen cell memory
// depends on tcce_pkg
//
// Each input word either interprets one character code (tuser 0) or reads back
// one screen cell (tuser 1) and returns exactly one result word with the cell
// data (zero for a character code) and the cursor position afterwards. For
// printable codes, backspace, tab, line feed, carriage return, ignored codes
// and cell reads the single-port-write cell memory is written or read in the
// accept cycle and the result is registered in ST_DONE once the output register
// is free; a cursor move past the bottom row starts a scroll instead. A form
// feed sweeps the whole screen one cell a cycle. A scroll copies one cell a
// cycle through the memory read port and then blanks the bottom row. After
// reset the memory is cleared to zero before the first word is taken.
// The attribute register can be written at any time the engine is idle.
module text_console_character_engine_unit #(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 25,
    parameter int TAB_STOP       = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [7:0] char_code, [18:8] cell_index, [23:19] zero
    input  logic [tcce_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // [0] mode
    input  logic                            i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [15:0] cell_data, [20:16] cursor_row, [27:21] cursor_col, [31:28] zero
    output logic [tcce_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input  logic                            i_cfg_wr_en,
    input  logic [7:0]                      i_cfg_wr_data
);
    import tcce_pkg::*;

    localparam int CELL_COUNT = SCREEN_ROWS * SCREEN_COLUMNS;
    localparam int AW   = $clog2(CELL_COUNT);
    localparam int IW   = (AW > INDEX_W) ? AW : INDEX_W;
    localparam int RW   = $clog2(SCREEN_ROWS);
    localparam int RW1  = $clog2(SCREEN_ROWS + 1);
    localparam int CW   = $clog2(SCREEN_COLUMNS);
    localparam int CWX  = $clog2(SCREEN_COLUMNS + TAB_STOP);
    localparam int PW   = $clog2(TAB_STOP);

    localparam logic [AW-1:0] ADDR_LAST     = AW'(CELL_COUNT - 1);
    localparam logic [AW-1:0] ADDR_SCR_LAST = AW'(CELL_COUNT - SCREEN_COLUMNS - 1);
    localparam logic [AW-1:0] ADDR_SRC0     = AW'(SCREEN_COLUMNS);
    localparam logic [AW-1:0] ADDR_SRC_OFS  = AW'(SCREEN_COLUMNS + 1);

    logic [CELL_W-1:0] mem [CELL_COUNT];

    t_state            r_state, n_state;
    logic [AW-1:0]     r_addr, n_addr;
    logic [RW-1:0]     r_row, n_row;
    logic [CW-1:0]     r_col, n_col;
    logic [PW-1:0]     r_phase, n_phase;
    logic [7:0]        r_attr, n_attr;
    logic              r_rd_hit, n_rd_hit;
    logic [CELL_W-1:0] r_rdata;
    logic              r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic              w_we, w_re, w_acc;
    logic [AW-1:0]     w_wa, w_ra, w_cur_addr;
    logic [CELL_W-1:0] w_wd;
    logic [7:0]        w_code;
    logic [IW-1:0]     w_idx;
    logic              w_idx_ok;
    logic [RW1-1:0]    c_row;
    logic [CWX-1:0]    c_col;
    logic [PW-1:0]     c_phase;
    logic              c_move, c_clear;

    assign w_code     = i_s_tdata[7:0];
    assign w_idx      = IW'(i_s_tdata[8 +: INDEX_W]);
    assign w_idx_ok   = w_idx < IW'(CELL_COUNT);
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_cur_addr = AW'(int'(r_row) * SCREEN_COLUMNS + int'(r_col));

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // cursor candidate for one character code
    always_comb begin
        c_row   = RW1'(r_row);
        c_col   = CWX'(r_col);
        c_phase = r_phase;
        c_move  = 1'b0;
        c_clear = 1'b0;
        priority if (w_code >= CH_PRINT_LO && w_code <= CH_PRINT_HI) begin
            c_move  = 1'b1;
            c_col   = CWX'(r_col) + CWX'(1);
            c_phase = (r_phase == PW'(TAB_STOP - 1)) ? '0 : r_phase + PW'(1);
        end else if (w_code == CH_BS) begin
            if (r_col != '0) begin
                c_move  = 1'b1;
                c_col   = CWX'(r_col) - CWX'(1);
                c_phase = (r_phase == '0) ? PW'(TAB_STOP - 1) : r_phase - PW'(1);
            end
        end else if (w_code == CH_TAB) begin
            c_move  = 1'b1;
            c_col   = CWX'(r_col) + CWX'(TAB_STOP) - CWX'(r_phase);
            c_phase = '0;
        end else if (w_code == CH_LF) begin
            c_move  = 1'b1;
            c_row   = RW1'(r_row) + RW1'(1);
            c_col   = '0;
            c_phase = '0;
        end else if (w_code == CH_FF) begin
            c_clear = 1'b1;
        end else if (w_code == CH_CR) begin
            c_move  = 1'b1;
            c_col   = '0;
            c_phase = '0;
        end else begin
            c_move  = 1'b0;
        end
        if (c_col > CWX'(SCREEN_COLUMNS - 1)) begin
            c_col   = '0;
            c_phase = '0;
            c_row   = c_row + RW1'(1);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_row       = r_row;
        n_col       = r_col;
        n_phase     = r_phase;
        n_rd_hit    = r_rd_hit;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        n_attr      = i_cfg_wr_en ? i_cfg_wr_data : r_attr;
        w_we        = 1'b0;
        w_wa        = r_addr;
        w_wd        = {r_attr, CH_SPACE};
        w_re        = 1'b0;
        w_ra        = r_addr + ADDR_SRC_OFS;
        unique case (r_state)
            ST_INIT: begin
                w_we = 1'b1;
                w_wd = '0;
                n_addr = r_addr + AW'(1);
                if (r_addr == ADDR_LAST) begin
                    n_addr  = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_acc) begin
                    n_state = ST_DONE;
                    if (i_s_tuser) begin
                        n_rd_hit = w_idx_ok;
                        w_re     = w_idx_ok;
                        w_ra     = w_idx[AW-1:0];
                    end else begin
                        n_rd_hit = 1'b0;
                        if (w_code >= CH_PRINT_LO && w_code <= CH_PRINT_HI) begin
                            w_we = 1'b1;
                            w_wa = w_cur_addr;
                            w_wd = {r_attr, w_code};
                        end
                        if (c_clear) begin
                            n_row   = '0;
                            n_col   = '0;
                            n_phase = '0;
                            n_addr  = '0;
                            n_state = ST_FILL;
                        end else if (c_move) begin
                            if (c_row > RW1'(SCREEN_ROWS - 1)) begin
                                n_row   = RW'(SCREEN_ROWS - 1);
                                n_col   = '0;
                                n_phase = '0;
                                n_addr  = '0;
                                n_state = ST_SCR_PRE;
                            end else begin
                                n_row   = RW'(c_row);
                                n_col   = CW'(c_col);
                                n_phase = c_phase;
                            end
                        end
                    end
                end
            end
            ST_FILL: begin
                w_we   = 1'b1;
                n_addr = r_addr + AW'(1);
                if (r_addr == ADDR_LAST) begin
                    n_addr  = '0;
                    n_state = ST_DONE;
                end
            end
            ST_SCR_PRE: begin
                w_re    = 1'b1;
                w_ra    = ADDR_SRC0;
                n_state = ST_SCR;
            end
            ST_SCR: begin
                w_we   = 1'b1;
                w_wd   = {r_attr, r_rdata[7:0]};
                w_re   = (r_addr != ADDR_SCR_LAST);
                n_addr = r_addr + AW'(1);
                if (r_addr == ADDR_SCR_LAST) begin
                    n_state = ST_BLANK;
                end
            end
            ST_BLANK: begin
                w_we   = 1'b1;
                n_addr = r_addr + AW'(1);
                if (r_addr == ADDR_LAST) begin
                    n_addr  = '0;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {4'b0, OUT_COL_W'(r_col), OUT_ROW_W'(r_row),
                                   r_rd_hit ? r_rdata : '0};
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_addr      <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_phase     <= '0;
            r_attr      <= ATTR_RESET;
            r_rd_hit    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_row       <= n_row;
            r_col       <= n_col;
            r_phase     <= n_phase;
            r_attr      <= n_attr;
            r_rd_hit    <= n_rd_hit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    // cell memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa] <= w_wd;
        end
        if (w_re) begin
            r_rdata <= mem[w_ra];
        end
    end

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_row) < SCREEN_ROWS) && (int'(r_col) < SCREEN_COLUMNS))
        else $error("cursor out of screen");

    a_read_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_s_tuser) |=> (r_state == ST_DONE))
        else $error("cell read did not finish in one cycle");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result word loaded outside done state");

    a_wr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (int'(w_wa) < CELL_COUNT))
        else $error("cell write address out of range");

    a_rd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_re |-> (int'(w_ra) < CELL_COUNT))
        else $error("cell read address out of range");

endmodule
